[sv/md5sh_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and round tables for the MD5 stream hasher.
// Used by md5sh_round and md5_stream_hasher; depends on nothing.
package md5sh_pkg;

  typedef logic [3:0][31:0] quad_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] idx;
  } rnd_ctrl_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam quad_t IV = {IV_D, IV_C, IV_B, IV_A};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amount per round: depends on the group and the round mod 4.
  function automatic logic [4:0] rot_amt(input logic [5:0] idx);
    logic [4:0] s;
    case ({idx[5:4], idx[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // Message word used by each round.
  function automatic logic [3:0] word_sel(input logic [5:0] idx);
    logic [3:0] i;
    logic [3:0] g;
    i = idx[3:0];
    case (idx[5:4])
      2'd0:    g = i;
      2'd1:    g = 4'(i * 4'd5 + 4'd1);
      2'd2:    g = 4'(i * 4'd3 + 4'd5);
      2'd3:    g = 4'(i * 4'd7);
      default: g = i;
    endcase
    return g;
  endfunction

endpackage

[sv/md5_stream_hasher.sv]
`timescale 1ns / 1ps
// MD5 stream hasher, top level: byte intake, padding, round sequencer, digest output.
// Depends on md5sh_pkg, md5sh_buf and md5sh_round.
// A byte that does not fill a block leaves in_ready high. The byte that fills a block
// adds a compression: a load, 64 rounds on the shared round unit, a chaining add.
// A last word writes padding, one byte per cycle (9..72 bytes), plus a compression
// per block it closes, then four digest words, one per cycle while out_ready is high.
// Reset (rst_n low, synchronous) reloads the initial chaining values and clears counts.
module md5_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // Where to go once a block is compressed
  localparam logic [1:0] RET_IDLE = 2'd0;
  localparam logic [1:0] RET_PAD  = 2'd1;
  localparam logic [1:0] RET_OUT  = 2'd2;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       ret_r, ret_nxt;
  logic [5:0]       fill_r, fill_nxt;
  logic [63:0]      bits_r, bits_nxt;
  md5sh_pkg::quad_t chain_r, chain_nxt;
  logic             sent80_r, sent80_nxt;
  logic             in_len_r, in_len_nxt;
  logic [2:0]       len_cnt_r, len_cnt_nxt;
  logic [5:0]       rnd_r, rnd_nxt;
  logic [1:0]       out_idx_r, out_idx_nxt;

  logic                 buf_we;
  logic [7:0]           buf_wdata;
  logic [3:0]           buf_raddr;
  logic [31:0]          buf_rword;
  md5sh_pkg::rnd_ctrl_t rnd_ctrl;
  md5sh_pkg::quad_t     work;
  logic                 len_write;

  md5sh_buf u_buf (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (fill_r),
    .wr_data (buf_wdata),
    .rd_addr (buf_raddr),
    .rd_word (buf_rword)
  );

  md5sh_round u_round (
    .clk      (clk),
    .ctrl     (rnd_ctrl),
    .chain_in (chain_r),
    .msg_word (buf_rword),
    .work_out (work)
  );

  // Round unit control; prefetch the word for the next round since buffer reads are
  // registered.
  always_comb begin
    rnd_ctrl.load = (state_r == S_LOAD);
    rnd_ctrl.step = (state_r == S_ROUND);
    rnd_ctrl.idx  = rnd_r;
    if (state_r == S_LOAD) begin
      buf_raddr = md5sh_pkg::word_sel(6'd0);
    end else begin
      buf_raddr = md5sh_pkg::word_sel(rnd_r + 6'd1);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    fill_nxt    = fill_r;
    bits_nxt    = bits_r;
    chain_nxt   = chain_r;
    sent80_nxt  = sent80_r;
    in_len_nxt  = in_len_r;
    len_cnt_nxt = len_cnt_r;
    rnd_nxt     = rnd_r;
    out_idx_nxt = out_idx_r;
    buf_we      = 1'b0;
    buf_wdata   = in_data_byte;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    len_write   = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_has_byte) begin
            buf_we   = 1'b1;
            fill_nxt = fill_r + 6'd1;
            bits_nxt = bits_r + 64'd8;
          end
          if (in_last) begin
            sent80_nxt  = 1'b0;
            in_len_nxt  = 1'b0;
            len_cnt_nxt = 3'd0;
          end
          if (in_has_byte && fill_r == md5sh_pkg::LAST_POS) begin
            // block full: compress, then pad or wait for more words
            state_nxt = S_LOAD;
            ret_nxt   = in_last ? RET_PAD : RET_IDLE;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end

      S_PAD: begin
        // Write one padding byte per cycle: the 0x80 marker, zeros, then the length
        buf_we   = 1'b1;
        fill_nxt = fill_r + 6'd1;
        if (!sent80_r) begin
          buf_wdata  = md5sh_pkg::PAD_BYTE;
          sent80_nxt = 1'b1;
        end else if (!in_len_r && fill_r != md5sh_pkg::LEN_POS) begin
          buf_wdata = 8'h00;
        end else begin
          len_write   = 1'b1;
          buf_wdata   = bits_r[{len_cnt_r, 3'b000} +: 8];
          in_len_nxt  = 1'b1;
          len_cnt_nxt = len_cnt_r + 3'd1;
        end
        if (fill_r == md5sh_pkg::LAST_POS) begin
          state_nxt = S_LOAD;
          ret_nxt   = len_write ? RET_OUT : RET_PAD;
        end
      end

      S_LOAD: begin
        rnd_nxt   = 6'd0;
        state_nxt = S_ROUND;
      end

      S_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end

      S_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_nxt[i] = chain_r[i] + work[i];
        end
        out_idx_nxt = 2'd0;
        case (ret_r)
          RET_PAD:  state_nxt = S_PAD;
          RET_OUT:  state_nxt = S_OUT;
          default:  state_nxt = S_IDLE;
        endcase
      end

      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          out_idx_nxt = out_idx_r + 2'd1;
          if (out_idx_r == 2'd3) begin
            // digest delivered: back to the initial state for the next message
            chain_nxt = md5sh_pkg::IV;
            bits_nxt  = 64'd0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= RET_IDLE;
      fill_r    <= 6'd0;
      bits_r    <= 64'd0;
      chain_r   <= md5sh_pkg::IV;
      sent80_r  <= 1'b0;
      in_len_r  <= 1'b0;
      len_cnt_r <= 3'd0;
      rnd_r     <= 6'd0;
      out_idx_r <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      fill_r    <= fill_nxt;
      bits_r    <= bits_nxt;
      chain_r   <= chain_nxt;
      sent80_r  <= sent80_nxt;
      in_len_r  <= in_len_nxt;
      len_cnt_r <= len_cnt_nxt;
      rnd_r     <= rnd_nxt;
      out_idx_r <= out_idx_nxt;
    end
  end

  assign out_digest_word = chain_r[out_idx_r];
  assign out_word_index  = out_idx_r;
  assign out_last_word   = (out_idx_r == 2'd3);

`ifndef SYNTHESIS
  // Compression only starts on a block boundary
  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> fill_r == 6'd0)
    else $error("compression started with a partial block");

  // Length bytes only land in the last eight slots of a block
  a_len_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PAD && in_len_r |-> fill_r >= md5sh_pkg::LEN_POS)
    else $error("length byte outside its slots");

  // The final round hands over to the chaining add
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND && rnd_r == 6'd63 |=> state_r == S_ADD)
    else $error("round sequence overran");

  // After the final digest word the block is clean for the next message
  a_clean_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_word |=>
      in_ready && fill_r == 6'd0 && bits_r == 64'd0 && chain_r == md5sh_pkg::IV)
    else $error("state not restored after digest");
`endif

endmodule

[sv/md5sh_buf.sv]
`timescale 1ns / 1ps
// 64-byte block buffer: byte-wide writes, registered 32-bit word reads.
// Uses no package items.
module md5sh_buf (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [5:0]  wr_addr,
  input  logic [7:0]  wr_data,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_word
);

  logic [3:0][7:0] mem_r [16];
  logic [31:0]     rd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr[5:2]][wr_addr[1:0]] <= wr_data;
    end
    rd_word_r <= mem_r[rd_addr];
  end

  assign rd_word = rd_word_r;

endmodule

[sv/md5sh_round.sv]
`timescale 1ns / 1ps
// Shared MD5 round unit: working registers A..D and one round of logic.
// Depends on md5sh_pkg for the round tables and control struct.
module md5sh_round (
  input  logic                 clk,
  input  md5sh_pkg::rnd_ctrl_t ctrl,
  input  md5sh_pkg::quad_t     chain_in,
  input  logic [31:0]          msg_word,
  output md5sh_pkg::quad_t     work_out
);

  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rot;
  logic [4:0]  s;

  always_comb begin
    case (ctrl.idx[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      2'd3:    f = c_r ^ (b_r | ~d_r);
      default: f = b_r ^ c_r ^ d_r;
    endcase
    s   = md5sh_pkg::rot_amt(ctrl.idx);
    sum = a_r + f + msg_word + md5sh_pkg::K_TAB[ctrl.idx];
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r <= chain_in[0];
      b_r <= chain_in[1];
      c_r <= chain_in[2];
      d_r <= chain_in[3];
    end else if (ctrl.step) begin
      a_r <= d_r;
      b_r <= b_r + rot;
      c_r <= b_r;
      d_r <= c_r;
    end
  end

  assign work_out = {d_r, c_r, b_r, a_r};

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for md5_stream_hasher: byte stream in, four digest words out.
// Needs only the hasher RTL; digests are predicted here by an MD5 model of its own.
module tb;

  // Idle/stall phases for the two channels.
  typedef enum logic [1:0] {
    PH_STEADY,      // no idling on either side
    PH_SEND_IDLE,   // sender idles at random, odds 80 in 100
    PH_RECV_STALL,  // receiver stalls at random, odds 80 in 100
    PH_BOTH         // both sides idle at random, odds 14 in 100
  } phase_e;

  typedef logic [3:0][31:0] quad_t;  // [0] is chaining word A

  // One expected digest word.
  typedef struct {
    logic [31:0] word;
    logic [1:0]  index;
    logic        final_word;
  } digest_word_t;

  // One row of the directed table; dig is checked only when typed is set.
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
    logic       typed;
    quad_t      dig;
  } stim_row_t;

  localparam int          RAND_ITEMS  = 280;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 200;
  localparam logic [7:0]  PAD_MARK    = 8'h80;
  localparam int unsigned LEN_POS     = 56;
  localparam int unsigned BLOCK_BYTES = 64;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;

  // Known digests, word A first in each literal's low slot.
  localparam quad_t DIG_EMPTY = {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4};
  localparam quad_t DIG_A     = {32'h61267769, 32'he299c331, 32'ha8b6f1c0, 32'hb975c10c};
  localparam quad_t DIG_ABC   = {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190};

  localparam logic [31:0] ADD_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, four per round group.
  localparam int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // Directed part: empty messages, the idle word, data ignored without has_byte,
  // textbook digests, byte extremes and a message with an idle word inside it.
  localparam int DIR_ROWS = 12;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, DIG_EMPTY},  // empty message right after reset
    '{8'hff, 1'b0, 1'b0, 1'b0, '0},         // idle word
    '{8'haa, 1'b0, 1'b1, 1'b1, DIG_EMPTY},  // data ignored without has_byte
    '{8'h61, 1'b1, 1'b1, 1'b1, DIG_A},      // byte and end in one word
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b1, DIG_ABC},
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, 1'b0, '0},         // idle word inside a message
    '{8'hff, 1'b1, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b1, 1'b0, '0},
    '{8'hff, 1'b1, 1'b1, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [1:0]  out_word_index;
  logic        out_last_word;

  md5_stream_hasher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_has_byte     (in_has_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hash state of the predictor.
  logic [31:0] chain_w [4];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] bit_count;

  digest_word_t digest_q [$];
  phase_e       phase = PH_STEADY;
  int           mismatches = 0;
  int           cycle_count = 0;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // Idle percentage for a side in the current phase.
  function automatic int rest_pct(input bit sender);
    case (phase)
      PH_SEND_IDLE:  return sender ? 80 : 0;
      PH_RECV_STALL: return sender ? 0 : 80;
      PH_BOTH:       return 14;
      default:       return 0;
    endcase
  endfunction

  task automatic hash_reset();
    chain_w[0] = H0;
    chain_w[1] = H1;
    chain_w[2] = H2;
    chain_w[3] = H3;
    fill = 0;
    bit_count = '0;
  endtask

  // Run the 64 steps over the buffered block and fold into the chaining words.
  task automatic md5_compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    for (int i = 0; i < 16; i++)
      m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + m[g] + ADD_TAB[r], SHIFT_TAB[(r / 16) * 4 + r % 4]);
      a = t;
    end
    chain_w[0] += a;
    chain_w[1] += b;
    chain_w[2] += c;
    chain_w[3] += d;
  endtask

  task automatic absorb_byte(input logic [7:0] v);
    blk[fill] = v;
    fill++;
    if (fill == BLOCK_BYTES) begin
      md5_compress();
      fill = 0;
    end
  endtask

  // Advance the predictor by one accepted word; done is set when a digest falls out.
  task automatic hash_word(input logic [7:0] data, input logic has, input logic fin,
                           output bit done, output quad_t dg);
    logic [63:0] len_bits;
    done = 1'b0;
    dg = '0;
    if (has) begin
      bit_count += 64'd8;
      absorb_byte(data);
    end
    if (fin) begin
      len_bits = bit_count;
      absorb_byte(PAD_MARK);
      while (fill != LEN_POS)
        absorb_byte(8'h00);
      for (int i = 0; i < 8; i++)
        absorb_byte(len_bits[8*i +: 8]);
      dg = {chain_w[3], chain_w[2], chain_w[1], chain_w[0]};
      done = 1'b1;
      hash_reset();
    end
  endtask

  // Offer one word, hold it until accepted, then predict. Called right after a
  // rising edge and returns right after the edge that took the word.
  task automatic send_word(input logic [7:0] data, input logic has, input logic fin,
                           input logic typed, input quad_t typed_dig);
    bit    taken;
    bit    done;
    quad_t dg;
    while ($urandom_range(99) < rest_pct(1'b1)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_has_byte  <= has;
    in_last      <= fin;
    // in_ready settles by the falling edge; inputs only move at rising edges.
    forever begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
      if (taken)
        break;
    end
    hash_word(data, has, fin, done, dg);
    if (done) begin
      if (typed)
        dg = typed_dig;
      for (int i = 0; i < 4; i++)
        digest_q.push_back('{word: dg[i], index: 2'(i), final_word: (i == 3)});
    end
  endtask

  // Drop valid and hold off until every expected digest word is back.
  task automatic drain_digests();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (digest_q.size() != 0);
  endtask

  // Receiver: stall at random per the current phase.
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= rest_pct(1'b0));

  // Check each digest word that will be taken at the next rising edge.
  always @(negedge clk) begin
    digest_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected digest word: expected none, actual word %h index %0d last %b",
                 $realtime, out_digest_word, out_word_index, out_last_word);
      end else begin
        e = digest_q.pop_front();
        if (out_digest_word !== e.word) begin
          mismatches++;
          $display("%0t digest_word: expected %h actual %h", $realtime, e.word,
                   out_digest_word);
        end
        if (out_word_index !== e.index) begin
          mismatches++;
          $display("%0t word_index: expected %0d actual %0d", $realtime, e.index,
                   out_word_index);
        end
        if (out_last_word !== e.final_word) begin
          mismatches++;
          $display("%0t last_word: expected %b actual %b", $realtime, e.final_word,
                   out_last_word);
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("md5_stream_hasher verification failed");
      $finish;
    end
  end

  initial begin
    int     items_sent;
    int     msg_len;
    int     msg_count;
    int     pick;
    phase_e next_phase;
    bit     fold_last;
    hash_reset();
    items_sent = 0;
    msg_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling.
    for (int r = 0; r < DIR_ROWS; r++)
      send_word(DIR_TAB[r].data, DIR_TAB[r].has, DIR_TAB[r].fin, DIR_TAB[r].typed,
                DIR_TAB[r].dig);
    drain_digests();

    // Random messages. Most are short; the first of the steady phase straddles the
    // one-block padding limit, the first of the stall phase forces a second block.
    while (items_sent < RAND_ITEMS) begin
      next_phase = phase_e'((items_sent * 4) / RAND_ITEMS);
      if (next_phase != phase) begin
        drain_digests();
        phase = next_phase;
        msg_count = 0;
      end
      pick = $urandom_range(19);
      if (msg_count == 0 && phase == PH_STEADY)
        msg_len = LEN_POS - 1;
      else if (msg_count == 0 && phase == PH_RECV_STALL)
        msg_len = LEN_POS;
      else if (pick == 0)
        msg_len = BLOCK_BYTES - 1;
      else if (pick == 1)
        msg_len = BLOCK_BYTES;
      else
        msg_len = $urandom_range(12);
      // Carry the end flag on the final byte half the time, else in a word of its own.
      fold_last = (msg_len > 0) && ($urandom_range(1) == 1);
      for (int k = 0; k < msg_len; k++) begin
        if ($urandom_range(7) == 0) begin
          send_word(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
          items_sent++;
        end
        send_word(8'($urandom), 1'b1, fold_last && (k == msg_len - 1), 1'b0, '0);
        items_sent++;
      end
      if (!fold_last) begin
        send_word(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
        items_sent++;
      end
      msg_count++;
    end

    // Wait for the last digests, then let the block settle.
    drain_digests();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && digest_q.size() == 0)
      $display("md5_stream_hasher verification clean");
    else
      $display("md5_stream_hasher verification failed");
    $finish;
  end

endmodule
